// ----- design/assert_macros.svh -----
// Assertion macros shared by the stationary detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SOG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted
`define SOG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- design/sog_pkg.sv -----
// Package: types, constants and tables for the stationary detector
package sog_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIAS,
    ST_DIFF,
    ST_SQ,
    ST_ROOT,
    ST_FILT,
    ST_TEST,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_FIRST = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  // unused code, handled like check off
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int SQRT_IN_W  = 64;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_OUT_W + 1);

  localparam logic [15:0] SCALE_RESET      = 16'd8192;
  localparam logic [31:0] GYRO_FILT_RESET  = 32'd13107;
  localparam logic [31:0] ACCEL_FILT_RESET = 32'd327680;
  localparam logic [15:0] W_OLD            = 16'd64881;
  localparam logic [15:0] W_NEW            = 16'd655;
  localparam logic [32:0] GRAVITY_Q16      = 33'd642689;

  // Threshold limits in Q.16
  function automatic logic [18:0] test_lim(input logic [1:0] idx);
    logic [18:0] v;
    case (idx)
      2'd0:    v = 19'd3431;
      2'd1:    v = 19'd65536;
      2'd2:    v = 19'd13107;
      default: v = 19'd327680;
    endcase
    return v;
  endfunction

  // Limits premultiplied by the 0.7 hysteresis (45875/65536)
  function automatic logic [33:0] hyst_lim(input logic [1:0] idx);
    logic [33:0] v;
    case (idx)
      2'd0:    v = 34'd157397125;
      2'd1:    v = 34'd3006464000;
      2'd2:    v = 34'd601283625;
      default: v = 34'd15032320000;
    endcase
    return v;
  endfunction

endpackage

// ----- design/sog_mul.sv -----
// Shared signed multiplier with registered product
module sog_mul (
  input  logic                         clk,
  input  logic [sog_pkg::MUL_A_W-1:0]  a_i,
  input  logic [sog_pkg::MUL_B_W-1:0]  b_i,
  output logic [sog_pkg::MUL_P_W-1:0]  p_o
);

  logic signed [sog_pkg::MUL_P_W-1:0] full;
  logic        [sog_pkg::MUL_P_W-1:0] p_r;

  assign full = $signed(a_i) * $signed(b_i);

  always_ff @(posedge clk) begin
    p_r <= full;
  end

  assign p_o = p_r;

endmodule

// ----- design/sog_isqrt.sv -----
// Iterative floor square root, one result bit per cycle
`include "assert_macros.svh"
module sog_isqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [sog_pkg::SQRT_IN_W-1:0]   rad,
  output sog_pkg::sq_stat_t               stat,
  output logic [sog_pkg::SQRT_OUT_W-1:0]  root
);

  localparam int RW = sog_pkg::SQRT_OUT_W + 3;

  logic [sog_pkg::SQRT_IN_W-1:0]  rad_r, rad_nxt;
  logic [RW-1:0]                  rem_r, rem_nxt;
  logic [sog_pkg::SQRT_OUT_W-1:0] root_r, root_nxt;
  logic [sog_pkg::SQRT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt, done_r, done_nxt;
  logic [RW-1:0]                  rem_sh, trial;

  assign rem_sh = {rem_r[RW-3:0], rad_r[sog_pkg::SQRT_IN_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = sog_pkg::SQRT_CNT_W'(sog_pkg::SQRT_OUT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[sog_pkg::SQRT_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[sog_pkg::SQRT_OUT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == sog_pkg::SQRT_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

  `SOG_ASSERT_NXT(a_sq_start_busy, clk, rst_n, start, busy_r)
  `SOG_ASSERT_IMP(a_sq_done_idle, clk, rst_n, done_r, !busy_r)

endmodule

// ----- design/stationary_on_ground_detector_unit.sv -----
// Top level: stationary-on-ground detector sequencer and state
//
// Usage:
//  - Input channel (in_*): one transaction carries a gyro sample, an accel
//    sample, both bias words, the inverse filter period and the ground mode.
//    in_stall is high from acceptance until the result is loaded, so one
//    transaction is worked at a time.
//  - Result channel (out_*): one transaction per input with the stationary
//    flag and the two filtered change levels. The result sits in an output
//    register; a new input is taken while it waits for the receiver.
//  - cfg_we/cfg_wdata write the threshold scale factor (Q4.12).
//  - Mode 0 (or 3) goes straight to loading the result; mode 1 does bias
//    correction only; mode 2 runs four square roots on the one bit-per-cycle
//    root unit and 36 products through the single shared multiplier plus
//    sequencing. The next input is taken the cycle after the result is
//    loaded.
//  - While out_stall holds a finished result, the next item stalls in its
//    final step until the output register frees up.
//  - Reset (synchronous, rst_n low) clears the flag and previous samples,
//    reloads the filters to 0.2 and 5.0 and the scale factor to 2.0.
`include "assert_macros.svh"
module stationary_on_ground_detector_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_ground_mode,
  input  logic [15:0] in_gyro_x,
  input  logic [15:0] in_gyro_y,
  input  logic [15:0] in_gyro_z,
  input  logic [15:0] in_accel_x,
  input  logic [15:0] in_accel_y,
  input  logic [15:0] in_accel_z,
  input  logic [47:0] in_gyro_bias_packed,
  input  logic [47:0] in_accel_bias_packed,
  input  logic [15:0] in_inverse_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_not_moving,
  output logic [15:0] out_gyro_change_level,
  output logic [15:0] out_accel_change_level
);

  localparam int AW = sog_pkg::MUL_A_W;
  localparam int BW = sog_pkg::MUL_B_W;

  // Control and architectural state
  sog_pkg::state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] scale_r;
  logic        flag_r, flag_nxt;
  logic        pend_r, pend_nxt;
  logic        any_hi_r, any_hi_nxt, all_lo_r, all_lo_nxt;
  logic [31:0] gf_r, gf_nxt, af_r, af_nxt;
  logic [15:0] pg_r [3], pg_nxt [3];
  logic [15:0] pa_r [3], pa_nxt [3];
  logic        out_valid_r, out_valid_nxt;

  // Captured transaction
  logic [1:0]  mode_r;
  logic [15:0] gin_r [3];
  logic [15:0] ain_r [3];
  logic [47:0] gbias_r, abias_r;
  logic [15:0] inv_r;

  // Working registers
  logic [15:0] g_r [3], g_nxt [3];
  logic [15:0] a_r [3], a_nxt [3];
  logic [30:0] mag_r [6];
  logic [30:0] mag_wr;
  logic        mag_we;
  logic [2:0]  mag_wa;
  logic [63:0] gs_r, gs_nxt, as_r, as_nxt;
  logic [31:0] gsq_r, gsq_nxt, asq_r, asq_nxt;
  logic [31:0] root_r [4], root_nxt [4];
  logic [48:0] facc_r, facc_nxt;
  logic        out_nm_r, out_nm_nxt;
  logic [15:0] out_gl_r, out_gl_nxt, out_al_r, out_al_nxt;

  // Shared units
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [sog_pkg::MUL_P_W-1:0] prod;
  logic sq_start;
  logic [sog_pkg::SQRT_IN_W-1:0]  sq_rad;
  logic [sog_pkg::SQRT_OUT_W-1:0] sq_root;
  sog_pkg::sq_stat_t sq_stat;

  // Datapath temporaries
  logic [3:0]  kc, jo, jc;
  logic [1:0]  cs_ax;
  logic        cs_acc;
  logic [32:0] p33, pmag;
  logic        pneg;
  logic [33:0] rnd, rr;
  logic [34:0] corr, smp35;
  logic [15:0] smp, bias_hw;
  logic [16:0] dd17;
  logic [49:0] fsum;
  logic [33:0] fnew;
  logic [32:0] an_s, adev;
  logic [63:0] xv;
  logic [32:0] lg, la;

  function automatic logic [15:0] sat16(input logic [34:0] v);
    logic [15:0] r;
    if ($signed(v) > 35'sd32767) r = 16'h7FFF;
    else if ($signed(v) < -35'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [15:0] half(input logic [47:0] w, input logic [1:0] ax);
    logic [15:0] r;
    case (ax)
      2'd0:    r = w[15:0];
      2'd1:    r = w[31:16];
      default: r = w[47:32];
    endcase
    return r;
  endfunction

  sog_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  sog_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_rad),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  assign in_stall = (state_r != sog_pkg::ST_IDLE);

  // Common decode of the product stage: op index in cnt_r, consume index one behind
  assign kc     = cnt_r - 4'd1;
  assign jo     = cnt_r - 4'd6;
  assign jc     = kc - 4'd6;
  assign cs_ax  = kc[2:1];
  assign cs_acc = kc[0];
  assign p33    = prod[32:0];
  assign pneg   = p33[32];
  assign pmag   = pneg ? (~p33 + 33'd1) : p33;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_rad = gs_r;
      2'd1:    sq_rad = as_r;
      2'd2:    sq_rad = {8'd0, gsq_r, 24'd0};
      default: sq_rad = {16'd0, asq_r, 16'd0};
    endcase
  end

  assign an_s = {1'b0, root_r[3]} - sog_pkg::GRAVITY_Q16;
  assign adev = an_s[32] ? (~an_s + 33'd1) : an_s;

  always_comb begin
    case (cs_ax)
      2'd0:    xv = {28'd0, root_r[2], 4'd0};
      2'd1:    xv = {19'd0, adev, 12'd0};
      2'd2:    xv = {20'd0, gf_r, 12'd0};
      default: xv = {20'd0, af_r, 12'd0};
    endcase
  end

  assign lg = ({1'b0, gf_r} + 33'd8) >> 4;
  assign la = ({1'b0, af_r} + 33'd128) >> 8;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    pend_nxt      = pend_r;
    any_hi_nxt    = any_hi_r;
    all_lo_nxt    = all_lo_r;
    gf_nxt        = gf_r;
    af_nxt        = af_r;
    pg_nxt        = pg_r;
    pa_nxt        = pa_r;
    g_nxt         = g_r;
    a_nxt         = a_r;
    gs_nxt        = gs_r;
    as_nxt        = as_r;
    gsq_nxt       = gsq_r;
    asq_nxt       = asq_r;
    root_nxt      = root_r;
    facc_nxt      = facc_r;
    out_nm_nxt    = out_nm_r;
    out_gl_nxt    = out_gl_r;
    out_al_nxt    = out_al_r;
    out_valid_nxt = out_valid_r;
    mul_a         = '0;
    mul_b         = '0;
    sq_start      = 1'b0;
    mag_we        = 1'b0;
    mag_wa        = kc[2:0];
    mag_wr        = '0;
    bias_hw       = '0;
    smp           = '0;
    smp35         = '0;
    rnd           = '0;
    rr            = '0;
    corr          = '0;
    dd17          = '0;
    fsum          = '0;
    fnew          = '0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      sog_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          if (in_ground_mode == sog_pkg::MODE_FIRST ||
              in_ground_mode == sog_pkg::MODE_RUN) begin
            state_nxt = sog_pkg::ST_BIAS;
          end else begin
            flag_nxt  = 1'b0;
            state_nxt = sog_pkg::ST_DONE;
          end
        end
      end

      // bias * inverse period, rounded and subtracted; gyro/accel interleaved per axis
      sog_pkg::ST_BIAS: begin
        if (cnt_r < 4'd6) begin
          bias_hw = half(cnt_r[0] ? abias_r : gbias_r, cnt_r[2:1]);
          mul_a   = {{(AW-16){bias_hw[15]}}, bias_hw};
          mul_b   = {{(BW-16){1'b0}}, inv_r};
        end
        if (cnt_r != 4'd0) begin
          rnd   = {1'b0, pmag} + (cs_acc ? 34'd16384 : 34'd1024);
          rr    = cs_acc ? (rnd >> 15) : (rnd >> 11);
          corr  = pneg ? (~{1'b0, rr} + 35'd1) : {1'b0, rr};
          smp   = cs_acc ? ain_r[cs_ax] : gin_r[cs_ax];
          smp35 = {{19{smp[15]}}, smp};
          if (cs_acc) a_nxt[cs_ax] = sat16(smp35 - corr);
          else        g_nxt[cs_ax] = sat16(smp35 - corr);
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd6) begin
          cnt_nxt = '0;
          if (mode_r == sog_pkg::MODE_FIRST) begin
            pg_nxt    = g_nxt;
            pa_nxt    = a_nxt;
            flag_nxt  = 1'b0;
            gf_nxt    = sog_pkg::GYRO_FILT_RESET;
            af_nxt    = sog_pkg::ACCEL_FILT_RESET;
            state_nxt = sog_pkg::ST_DONE;
          end else begin
            state_nxt = sog_pkg::ST_DIFF;
          end
        end
      end

      // change rates: (sample - previous) * inverse period
      sog_pkg::ST_DIFF: begin
        if (cnt_r < 4'd6) begin
          dd17 = cnt_r[0]
               ? ({a_r[cnt_r[2:1]][15], a_r[cnt_r[2:1]]} -
                  {pa_r[cnt_r[2:1]][15], pa_r[cnt_r[2:1]]})
               : ({g_r[cnt_r[2:1]][15], g_r[cnt_r[2:1]]} -
                  {pg_r[cnt_r[2:1]][15], pg_r[cnt_r[2:1]]});
          mul_a = {{(AW-17){dd17[16]}}, dd17};
          mul_b = {{(BW-16){1'b0}}, inv_r};
        end
        if (cnt_r != 4'd0) begin
          mag_we = 1'b1;
          if (cs_acc) begin
            mag_wr = (pmag > 33'h07FFFFFFF) ? 31'h7FFFFFFF : pmag[30:0];
          end else begin
            rnd    = {1'b0, pmag} + 34'd8;
            mag_wr = {1'b0, rnd[33:4]};
          end
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd6) begin
          cnt_nxt   = '0;
          gs_nxt    = '0;
          as_nxt    = '0;
          gsq_nxt   = '0;
          asq_nxt   = '0;
          state_nxt = sog_pkg::ST_SQ;
        end
      end

      // squares: six change magnitudes, then six corrected samples
      sog_pkg::ST_SQ: begin
        if (cnt_r < 4'd6) begin
          mul_a = {{(AW-31){1'b0}}, mag_r[cnt_r[2:0]]};
          mul_b = {{(BW-31){1'b0}}, mag_r[cnt_r[2:0]]};
        end else if (cnt_r < 4'd12) begin
          smp   = jo[0] ? a_r[jo[2:1]] : g_r[jo[2:1]];
          mul_a = {{(AW-16){smp[15]}}, smp};
          mul_b = {{(BW-16){smp[15]}}, smp};
        end
        if (cnt_r != 4'd0) begin
          if (kc < 4'd6) begin
            if (cs_acc) as_nxt = as_r + prod[63:0];
            else        gs_nxt = gs_r + prod[63:0];
          end else begin
            if (jc[0]) asq_nxt = asq_r + prod[31:0];
            else       gsq_nxt = gsq_r + prod[31:0];
          end
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd12) begin
          pg_nxt    = g_r;
          pa_nxt    = a_r;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = sog_pkg::ST_ROOT;
        end
      end

      // four roots in turn on the shared unit
      sog_pkg::ST_ROOT: begin
        if (!pend_r) begin
          sq_start = 1'b1;
          pend_nxt = 1'b1;
        end else if (sq_stat.done) begin
          root_nxt[cnt_r[1:0]] = sq_root;
          pend_nxt = 1'b0;
          if (cnt_r == 4'd3) begin
            cnt_nxt   = '0;
            state_nxt = sog_pkg::ST_FILT;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end

      // f = (f*W_OLD + n*W_NEW + half) >> 16, gyro then accel
      sog_pkg::ST_FILT: begin
        if (cnt_r < 4'd4) begin
          case (cnt_r[1:0])
            2'd0:    mul_a = {{(AW-32){1'b0}}, gf_r};
            2'd1:    mul_a = {{(AW-32){1'b0}}, root_r[0]};
            2'd2:    mul_a = {{(AW-32){1'b0}}, af_r};
            default: mul_a = {{(AW-32){1'b0}}, root_r[1]};
          endcase
          mul_b = {{(BW-16){1'b0}}, cnt_r[0] ? sog_pkg::W_NEW : sog_pkg::W_OLD};
        end
        if (cnt_r != 4'd0) begin
          if (!kc[0]) begin
            facc_nxt = prod[48:0];
          end else begin
            fsum = {1'b0, facc_r} + {1'b0, prod[48:0]} + 50'd32768;
            fnew = fsum[49:16];
            if (kc[1]) af_nxt = (|fnew[33:32]) ? 32'hFFFFFFFF : fnew[31:0];
            else       gf_nxt = (|fnew[33:32]) ? 32'hFFFFFFFF : fnew[31:0];
          end
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd4) begin
          cnt_nxt    = '0;
          any_hi_nxt = 1'b0;
          all_lo_nxt = 1'b1;
          state_nxt  = sog_pkg::ST_TEST;
        end
      end

      // per quantity: S*L for the exceed test, S*L*0.7 for the below test
      sog_pkg::ST_TEST: begin
        if (cnt_r < 4'd8) begin
          if (!cnt_r[0]) begin
            mul_a = {{(AW-16){1'b0}}, scale_r};
            mul_b = {{(BW-19){1'b0}}, sog_pkg::test_lim(cnt_r[2:1])};
          end else begin
            mul_a = {{(AW-34){1'b0}}, sog_pkg::hyst_lim(cnt_r[2:1])};
            mul_b = {{(BW-16){1'b0}}, scale_r};
          end
        end
        if (cnt_r != 4'd0) begin
          if (!cs_acc) begin
            if (xv > prod[63:0]) any_hi_nxt = 1'b1;
          end else begin
            if (!({xv[47:0], 16'd0} < prod[63:0])) all_lo_nxt = 1'b0;
          end
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd8) begin
          cnt_nxt   = '0;
          state_nxt = sog_pkg::ST_DECIDE;
        end
      end

      // hysteresis update of the flag
      sog_pkg::ST_DECIDE: begin
        if (flag_r) begin
          if (any_hi_r) flag_nxt = 1'b0;
        end else if (all_lo_r) begin
          flag_nxt = 1'b1;
        end
        state_nxt = sog_pkg::ST_DONE;
      end

      sog_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nm_nxt    = flag_r;
          out_gl_nxt    = (|lg[32:16]) ? 16'hFFFF : lg[15:0];
          out_al_nxt    = (|la[32:16]) ? 16'hFFFF : la[15:0];
          state_nxt     = sog_pkg::ST_IDLE;
        end
      end

      default: state_nxt = sog_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sog_pkg::ST_IDLE;
      cnt_r       <= '0;
      scale_r     <= sog_pkg::SCALE_RESET;
      flag_r      <= 1'b0;
      pend_r      <= 1'b0;
      any_hi_r    <= 1'b0;
      all_lo_r    <= 1'b1;
      gf_r        <= sog_pkg::GYRO_FILT_RESET;
      af_r        <= sog_pkg::ACCEL_FILT_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pg_r[i] <= '0;
        pa_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) scale_r <= cfg_wdata;
      flag_r      <= flag_nxt;
      pend_r      <= pend_nxt;
      any_hi_r    <= any_hi_nxt;
      all_lo_r    <= all_lo_nxt;
      gf_r        <= gf_nxt;
      af_r        <= af_nxt;
      out_valid_r <= out_valid_nxt;
      pg_r        <= pg_nxt;
      pa_r        <= pa_nxt;
    end
  end

  // Payload and working registers, no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      mode_r   <= in_ground_mode;
      gin_r[0] <= in_gyro_x;
      gin_r[1] <= in_gyro_y;
      gin_r[2] <= in_gyro_z;
      ain_r[0] <= in_accel_x;
      ain_r[1] <= in_accel_y;
      ain_r[2] <= in_accel_z;
      gbias_r  <= in_gyro_bias_packed;
      abias_r  <= in_accel_bias_packed;
      inv_r    <= in_inverse_period;
    end
    if (mag_we) mag_r[mag_wa] <= mag_wr;
    g_r      <= g_nxt;
    a_r      <= a_nxt;
    gs_r     <= gs_nxt;
    as_r     <= as_nxt;
    gsq_r    <= gsq_nxt;
    asq_r    <= asq_nxt;
    root_r   <= root_nxt;
    facc_r   <= facc_nxt;
    out_nm_r <= out_nm_nxt;
    out_gl_r <= out_gl_nxt;
    out_al_r <= out_al_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_not_moving         = out_nm_r;
  assign out_gyro_change_level  = out_gl_r;
  assign out_accel_change_level = out_al_r;

  `SOG_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != sog_pkg::ST_IDLE)
  `SOG_ASSERT_IMP(a_flag_set_run, clk, rst_n, $rose(flag_r), mode_r == sog_pkg::MODE_RUN)
  `SOG_ASSERT_IMP(a_root_start_free, clk, rst_n, sq_start, !sq_stat.busy)

endmodule

// ----- test/tb.sv -----
// Testbench for the stationary-on-ground detector: randomized traffic checked against a predictor
`timescale 1ns / 100ps

module tb;

  // One input transaction as driven onto the in_* ports
  typedef struct {
    logic [1:0]  mode;
    logic [15:0] gyro[3];
    logic [15:0] accel[3];
    logic [47:0] gbias_word;
    logic [47:0] abias_word;
    logic [15:0] inv_period;
  } imu_sample_t;

  typedef struct {
    logic        not_moving;
    logic [15:0] gyro_level;
    logic [15:0] accel_level;
  } detect_result_t;

  // Scoreboard: keeps its own copy of detector state and the queue of
  // expected result transactions.
  class ground_scoreboard;
    logic [15:0]    scale;
    longint         last_gyro[3];
    longint         last_accel[3];
    logic [31:0]    gyro_filt;
    logic [31:0]    accel_filt;
    bit             still;
    detect_result_t expected_q[$];
    int             errors;

    function void clear();
      scale = sog_pkg::SCALE_RESET;
      for (int i = 0; i < 3; i++) begin
        last_gyro[i] = 0;
        last_accel[i] = 0;
      end
      gyro_filt = sog_pkg::GYRO_FILT_RESET;
      accel_filt = sog_pkg::ACCEL_FILT_RESET;
      still = 0;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Magnitude round half away from zero, then shift
    function longint round_shift(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [63:0] clipped_square(longint v);
      logic [63:0] m;
      m = (v < 0) ? -v : v;
      if (m > 64'd2147483647) m = 64'd2147483647;
      return m * m;
    endfunction

    function logic [31:0] lowpass(logic [31:0] f, logic [63:0] n);
      logic [63:0] r;
      r = ({32'd0, f} * sog_pkg::W_OLD + n * sog_pkg::W_NEW + 64'd32768) >> 16;
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function logic [15:0] level(logic [31:0] f, int s);
      logic [63:0] r;
      r = ({32'd0, f} + (64'd1 << (s - 1))) >> s;
      return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    // Works out the result of one accepted sample and queues it
    function void note_sample(imu_sample_t it);
      longint inv, gc[3], ac[3], dg, da, an;
      logic [63:0] gs, as_, gsq, asq, gn, adev, t;
      logic [63:0] x[4], lim[4];
      bit any_hi, all_lo;
      detect_result_t r;
      inv = it.inv_period;
      gs = 0; as_ = 0; gsq = 0; asq = 0;
      any_hi = 0; all_lo = 1;
      for (int i = 0; i < 3; i++) begin
        gc[i] = clip16(longint'($signed(it.gyro[i]))
                - round_shift(longint'($signed(it.gbias_word[16*i +: 16])) * inv, 11));
        ac[i] = clip16(longint'($signed(it.accel[i]))
                - round_shift(longint'($signed(it.abias_word[16*i +: 16])) * inv, 15));
      end
      if (it.mode == sog_pkg::MODE_FIRST) begin
        for (int i = 0; i < 3; i++) begin
          last_gyro[i] = gc[i];
          last_accel[i] = ac[i];
        end
        still = 0;
        gyro_filt = sog_pkg::GYRO_FILT_RESET;
        accel_filt = sog_pkg::ACCEL_FILT_RESET;
      end else if (it.mode == sog_pkg::MODE_RUN) begin
        for (int i = 0; i < 3; i++) begin
          dg = round_shift((gc[i] - last_gyro[i]) * inv, 4);
          da = (ac[i] - last_accel[i]) * inv;
          gs += clipped_square(dg);
          as_ += clipped_square(da);
          last_gyro[i] = gc[i];
          last_accel[i] = ac[i];
          gsq += gc[i] * gc[i];
          asq += ac[i] * ac[i];
        end
        gyro_filt = lowpass(gyro_filt, int_sqrt(gs));
        accel_filt = lowpass(accel_filt, int_sqrt(as_));
        gn = int_sqrt(gsq << 24);
        an = longint'(int_sqrt(asq << 16)) - 642689;
        adev = (an < 0) ? -an : an;
        x[0] = gn << 4;
        x[1] = adev << 12;
        x[2] = {32'd0, gyro_filt} << 12;
        x[3] = {32'd0, accel_filt} << 12;
        lim[0] = 3431; lim[1] = 65536; lim[2] = 13107; lim[3] = 327680;
        for (int i = 0; i < 4; i++) begin
          t = scale * lim[i];
          if (x[i] > t) any_hi = 1;
          if (!((x[i] << 16) < t * 64'd45875)) all_lo = 0;
        end
        if (still) begin
          if (any_hi) still = 0;
        end else if (all_lo) begin
          still = 1;
        end
      end else begin
        // check off, and the unused fourth mode
        still = 0;
      end
      r.not_moving = still;
      r.gyro_level = level(gyro_filt, 4);
      r.accel_level = level(accel_filt, 8);
      expected_q.push_back(r);
    endfunction

    task check_result(logic nm, logic [15:0] gl, logic [15:0] al);
      detect_result_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result transaction", 1, 0);
        return;
      end
      e = expected_q.pop_front();
      if (nm !== e.not_moving) report("not_moving", nm, e.not_moving);
      if (gl !== e.gyro_level) report("gyro_change_level", gl, e.gyro_level);
      if (al !== e.accel_level) report("accel_change_level", al, e.accel_level);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [15:0] cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_ground_mode = 0;
  logic [15:0] in_gyro_x = 0, in_gyro_y = 0, in_gyro_z = 0;
  logic [15:0] in_accel_x = 0, in_accel_y = 0, in_accel_z = 0;
  logic [47:0] in_gyro_bias_packed = 0, in_accel_bias_packed = 0;
  logic [15:0] in_inverse_period = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_not_moving;
  logic [15:0] out_gyro_change_level, out_accel_change_level;

  ground_scoreboard sb = new();
  bit idle_on = 1;      // random idling on both channels
  int quiet_cycles = 0; // watchdog: cycles with no transaction

  stationary_on_ground_detector_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Receiver stalls at random, changed only at the falling edge
  always @(negedge clk) out_stall = idle_on && rst_n && ($urandom_range(99) < 7);

  // Result monitor and watchdog, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_not_moving, out_gyro_change_level, out_accel_change_level);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles > 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Drive one sample and hold it until the detector takes it
  task automatic send(imu_sample_t it);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 7) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_ground_mode = it.mode;
    {in_gyro_x, in_gyro_y, in_gyro_z} = {it.gyro[0], it.gyro[1], it.gyro[2]};
    {in_accel_x, in_accel_y, in_accel_z} = {it.accel[0], it.accel[1], it.accel[2]};
    in_gyro_bias_packed = it.gbias_word;
    in_accel_bias_packed = it.abias_word;
    in_inverse_period = it.inv_period;
    do @(posedge clk); while (in_stall);
    sb.note_sample(it);
    @(negedge clk);
    in_valid = 0;
  endtask

  // Pause until every result is back, then write the scale factor
  task automatic write_scale(logic [15:0] v);
    wait (sb.expected_q.size() == 0);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.scale = v;
  endtask

  function automatic logic [15:0] small_signed(int span);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [47:0] small_bias(int span);
    return {small_signed(span), small_signed(span), small_signed(span)};
  endfunction

  // Sitting still: tiny rates, accel close to 1 g on one axis
  function automatic imu_sample_t quiet_sample(logic [1:0] mode);
    imu_sample_t it;
    int ax;
    ax = $urandom_range(2);
    it.mode = mode;
    for (int i = 0; i < 3; i++) begin
      it.gyro[i] = small_signed(($urandom_range(9) == 0) ? 2000 : 60);
      it.accel[i] = small_signed(($urandom_range(9) == 0) ? 800 : 40);
    end
    it.accel[ax] = it.accel[ax] + (($urandom_range(1) == 1) ? 16'd2510 : -16'd2510);
    it.gbias_word = small_bias(200);
    it.abias_word = small_bias(3000);
    it.inv_period = $urandom_range(1) ? 16'($urandom_range(1, 2000)) : 16'($urandom());
    return it;
  endfunction

  function automatic imu_sample_t noise_sample();
    imu_sample_t it;
    it.mode = 2'($urandom_range(3));
    for (int i = 0; i < 3; i++) begin
      it.gyro[i] = 16'($urandom());
      it.accel[i] = 16'($urandom());
    end
    it.gbias_word = 48'({$urandom(), $urandom()});
    it.abias_word = 48'({$urandom(), $urandom()});
    it.inv_period = $urandom_range(20) == 0 ? 16'd0 : 16'($urandom());
    return it;
  endfunction

  function automatic imu_sample_t fixed_sample(logic [1:0] mode, logic [15:0] g,
                                               logic [15:0] a, logic [47:0] b,
                                               logic [15:0] inv);
    imu_sample_t it;
    it.mode = mode;
    for (int i = 0; i < 3; i++) begin
      it.gyro[i] = g;
      it.accel[i] = a;
    end
    it.gbias_word = b;
    it.abias_word = b;
    it.inv_period = inv;
    return it;
  endfunction

  // Mostly well-formed ground runs: first sample, then a run of samples
  task automatic ground_phase(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send(noise_sample());
        sent++;
      end else begin
        send(quiet_sample(sog_pkg::MODE_FIRST));
        sent++;
        repeat ($urandom_range(10, 60)) begin
          send(quiet_sample($urandom_range(29) == 0 ? sog_pkg::MODE_OFF : sog_pkg::MODE_RUN));
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb.clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: field extremes, each mode, zero inverse period
    send(fixed_sample(sog_pkg::MODE_OFF, 16'h0000, 16'h0000, 48'h0, 16'd256));
    send(fixed_sample(sog_pkg::MODE_RUN, 16'h0000, 16'h0000, 48'h0, 16'd256));
    send(fixed_sample(sog_pkg::MODE_FIRST, 16'h7FFF, 16'h8000, {3{16'h7FFF}}, 16'hFFFF));
    send(fixed_sample(sog_pkg::MODE_RUN, 16'h8000, 16'h7FFF, {3{16'h8000}}, 16'hFFFF));
    send(fixed_sample(sog_pkg::MODE_RUN, 16'h7FFF, 16'h8000, {3{16'h8000}}, 16'hFFFF));
    send(fixed_sample(sog_pkg::MODE_RUN, 16'h0000, 16'h0000, {3{16'hFFFF}}, 16'd0));
    send(fixed_sample(sog_pkg::MODE_SPARE, 16'h1234, 16'h0A00, 48'h0, 16'd1));
    send(fixed_sample(sog_pkg::MODE_FIRST, 16'h0000, 16'd1450, 48'h0, 16'd1000));
    repeat (6) send(fixed_sample(sog_pkg::MODE_RUN, 16'h0000, 16'd1450, 48'h0, 16'd1000));
    send(fixed_sample(sog_pkg::MODE_RUN, 16'h0400, 16'd1450, 48'h0, 16'd1000));
    send(fixed_sample(sog_pkg::MODE_OFF, 16'h0000, 16'd1450, 48'h0, 16'd1000));
    send(fixed_sample(sog_pkg::MODE_RUN, 16'hFFFF, 16'hFFFF, {3{16'hFFFF}}, 16'd1));

    // Random phases over several scale settings, extremes included;
    // one phase runs with no idling at all
    ground_phase(280);
    write_scale(16'd0);
    ground_phase(200);
    write_scale(16'hFFFF);
    idle_on = 0;
    ground_phase(280);
    idle_on = 1;
    write_scale(16'd4096);
    ground_phase(280);
    write_scale(16'($urandom()));
    ground_phase(280);
    write_scale(sog_pkg::SCALE_RESET);
    ground_phase(280);

    wait (sb.expected_q.size() == 0);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
